FILE: design/rrem_pkg.sv
// Package for the round-robin event multiplexer.
// Holds field widths, command and register codes, and the structs passed between modules.
// No dependencies.
`default_nettype none

package rrem_pkg;

   localparam int CMD_W       = 2;
   localparam int ID_W        = 8;
   localparam int GRANT_W     = 4;
   localparam int LAST_W      = 4;
   localparam int CFG_COUNT_W = 5;
   localparam int MASK_W      = 16;
   localparam int TOTAL_W     = 12;
   localparam int APB_DATA_W  = 32;
   localparam int APB_ADDR_W  = 3;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_SET   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_POLL  = 2'd2
   } cmd_type;

   typedef enum logic {
      REG_EVENT_COUNT = 1'b0,
      REG_MANUAL_MASK = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [CFG_COUNT_W-1:0] event_count;
      logic [MASK_W-1:0]      manual_mask;
   } cfg_type;

   typedef struct packed {
      logic clear_all;
      logic inc;
      logic dec;
   } cnt_ctrl_type;

   typedef struct packed {
      logic            found;
      logic [ID_W-1:0] index;
   } grant_type;

endpackage

`default_nettype wire

FILE: design/rrem_req_if.sv
// Command channel interface of the event multiplexer: valid, ready and one command.
// Depends on rrem_pkg for the field widths.
`default_nettype none

interface rrem_req_if;
   import rrem_pkg::*;

   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [ID_W-1:0]  event_id;

   modport source (output valid, command, event_id, input ready);
   modport sink   (input valid, command, event_id, output ready);

endinterface

`default_nettype wire

FILE: design/rrem_rsp_if.sv
// Result channel interface of the event multiplexer: valid, ready and one result.
// Depends on rrem_pkg for the field widths.
`default_nettype none

interface rrem_rsp_if;
   import rrem_pkg::*;

   logic               valid;
   logic               ready;
   logic               accepted;
   logic               grant_valid;
   logic [GRANT_W-1:0] grant_index;

   modport source (output valid, accepted, grant_valid, grant_index, input ready);
   modport sink   (input valid, accepted, grant_valid, grant_index, output ready);

endinterface

`default_nettype wire

FILE: design/rrem_csr.sv
// APB-style register file: event_count at byte address 0, manual_mask at byte address 4.
// Depends on rrem_pkg. Emits a one-cycle clear pulse whenever event_count is written.
`default_nettype none

module rrem_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [rrem_pkg::APB_ADDR_W-1:0]  paddr,
   input  wire logic [rrem_pkg::APB_DATA_W-1:0]  pwdata,
   output      logic [rrem_pkg::APB_DATA_W-1:0]  prdata,
   output      logic                             pready,
   output      rrem_pkg::cfg_type                cfg,
   output      logic                             cfg_clear
);
   import rrem_pkg::*;

   logic [CFG_COUNT_W-1:0] event_count_ff, event_count_in;
   logic [MASK_W-1:0]      manual_mask_ff, manual_mask_in;
   logic                   wr_en;
   reg_index_type          reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign reg_index = reg_index_type'(paddr[2]);

   always_comb begin
      event_count_in = event_count_ff;
      manual_mask_in = manual_mask_ff;
      cfg_clear      = 1'b0;
      if (wr_en) begin
         unique case (reg_index)
            REG_EVENT_COUNT: begin
               event_count_in = pwdata[CFG_COUNT_W-1:0];
               cfg_clear      = 1'b1;
            end
            REG_MANUAL_MASK: begin
               manual_mask_in = pwdata[MASK_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         event_count_ff <= '0;
         manual_mask_ff <= '0;
      end else begin
         event_count_ff <= event_count_in;
         manual_mask_ff <= manual_mask_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_EVENT_COUNT: prdata = {{(APB_DATA_W-CFG_COUNT_W){1'b0}}, event_count_ff};
         REG_MANUAL_MASK: prdata = {{(APB_DATA_W-MASK_W){1'b0}}, manual_mask_ff};
         default:         prdata = '0;
      endcase
   end

   assign cfg.event_count = event_count_ff;
   assign cfg.manual_mask = manual_mask_ff;

endmodule

`default_nettype wire

FILE: design/rrem_counters.sv
// Bank of per-event pending counters, one lane per event.
// Depends on rrem_pkg. Each lane updates only itself from a shared lane select.
`default_nettype none

module rrem_counters #(
   parameter int MAX_EVENTS  = 16,
   parameter int COUNT_WIDTH = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rrem_pkg::cnt_ctrl_type  ctrl,
   input  wire logic [MAX_EVENTS-1:0]   lane_sel,
   output      logic [MAX_EVENTS-1:0]   nonzero,
   output      logic [MAX_EVENTS-1:0]   full
);
   import rrem_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff [MAX_EVENTS];
   logic [COUNT_WIDTH-1:0] count_in [MAX_EVENTS];

   always_comb begin
      for (int i = 0; i < MAX_EVENTS; i++) begin
         count_in[i] = count_ff[i];
         if (ctrl.clear_all) begin
            count_in[i] = '0;
         end else if (lane_sel[i] && ctrl.inc) begin
            count_in[i] = count_ff[i] + COUNT_WIDTH'(1);
         end else if (lane_sel[i] && ctrl.dec) begin
            count_in[i] = count_ff[i] - COUNT_WIDTH'(1);
         end
         nonzero[i] = |count_ff[i];
         full[i]    = &count_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_EVENTS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < MAX_EVENTS; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/rrem_rr_pick.sv
// Rotating priority encoder: first pending lane above the last grant, else the first overall.
// Depends on rrem_pkg for the grant struct and index widths.
`default_nettype none

module rrem_rr_pick #(
   parameter int MAX_EVENTS = 16
) (
   input  wire logic [MAX_EVENTS-1:0]      pending,
   input  wire logic [rrem_pkg::LAST_W-1:0] last,
   output      rrem_pkg::grant_type         grant
);
   import rrem_pkg::*;

   logic [ID_W-1:0] last_ext;
   logic [ID_W-1:0] hi_idx, lo_idx;
   logic            hi_found, lo_found;

   assign last_ext = {{(ID_W-LAST_W){1'b0}}, last};

   always_comb begin
      hi_idx   = '0;
      lo_idx   = '0;
      hi_found = 1'b0;
      lo_found = 1'b0;
      // Walk from the top so the lowest matching lane wins.
      for (int i = MAX_EVENTS - 1; i >= 0; i--) begin
         if (pending[i]) begin
            lo_idx   = ID_W'(i);
            lo_found = 1'b1;
            if (ID_W'(i) > last_ext) begin
               hi_idx   = ID_W'(i);
               hi_found = 1'b1;
            end
         end
      end
      grant.found = lo_found;
      grant.index = hi_found ? hi_idx : lo_idx;
   end

endmodule

`default_nettype wire

FILE: design/round_robin_event_multiplexer_core.sv
// Round-robin event multiplexer, top level.
// Commands arrive on req_ch as a transfer of command and event_id. A set command adds one
// pending signal to an event, a clear command takes one away from a manual event, and a
// poll grants the next pending event in round-robin order after the last one granted.
// Every command gives exactly one result transfer on rsp_ch (accepted, grant_valid,
// grant_index), in command order. Two registers are set through the csr_ port:
// event_count (byte address 0), which also wipes all pending state when written, and
// manual_mask (byte address 4); the user must write configuration only while the block is
// idle, which the block does not enforce. A command taken from req_ch sits in the input
// register, is executed against the counters when the result register is free or being
// emptied, and lands in the result register, which drives rsp_ch. Throughput is one command
// per cycle while the receiver takes results: the input register refills in the same cycle
// its item moves to the result register; the priority encoder and counter update are combinational.
// When the receiver stalls, the result register holds its transfer and the input
// register takes one more command; req_ch.ready then drops until the result moves on.
// Reset (synchronous, active high) clears both registers, all counters, the total and
// the last grant; no clearing pass is needed and commands are taken right after reset.
// Depends on rrem_pkg, rrem_req_if, rrem_rsp_if, rrem_csr, rrem_counters, rrem_rr_pick.
`default_nettype none

module round_robin_event_multiplexer_core #(
   parameter int MAX_EVENTS  = 16,
   parameter int COUNT_WIDTH = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   rrem_req_if.sink                              req_ch,
   rrem_rsp_if.source                            rsp_ch,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [rrem_pkg::APB_ADDR_W-1:0]  csr_paddr,
   input  wire logic [rrem_pkg::APB_DATA_W-1:0]  csr_pwdata,
   output      logic [rrem_pkg::APB_DATA_W-1:0]  csr_prdata,
   output      logic                             csr_pready
);
   import rrem_pkg::*;

   localparam logic [ID_W-1:0] MAX_EV_W = ID_W'(MAX_EVENTS);

   // Configuration.
   cfg_type cfg;
   logic    cfg_clear;

   rrem_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .cfg       (cfg),
      .cfg_clear (cfg_clear)
   );

   // Input register.
   logic             in_valid_ff, in_valid_in;
   logic [CMD_W-1:0] in_cmd_ff, in_cmd_in;
   logic [ID_W-1:0]  in_id_ff, in_id_in;

   // Result register.
   logic               out_valid_ff, out_valid_in;
   logic               out_acc_ff, out_acc_in;
   logic               out_gv_ff, out_gv_in;
   logic [GRANT_W-1:0] out_gi_ff, out_gi_in;

   // Shared state outside the counter bank.
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [LAST_W-1:0]  last_ff, last_in;

   logic fire;
   logic req_ready;

   // The item in the input register executes when the result register is free or is
   // being emptied in this same cycle.
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ready = !in_valid_ff || fire;
   assign req_ch.ready = req_ready;

   // Number of events in use, clamped to the lanes that exist.
   logic [ID_W-1:0] ec_ext, n_ev;
   assign ec_ext = {{(ID_W-CFG_COUNT_W){1'b0}}, cfg.event_count};
   assign n_ev   = (ec_ext > MAX_EV_W) ? MAX_EV_W : ec_ext;

   // Per-lane qualifiers.
   logic [MAX_EVENTS-1:0] in_use, manual, id_sel, grant_sel, pending;
   logic [MAX_EVENTS-1:0] nonzero, full, lane_sel;
   grant_type             grant;

   always_comb begin
      for (int i = 0; i < MAX_EVENTS; i++) begin
         in_use[i]    = ID_W'(i) < n_ev;
         // Only the first sixteen events can be manual.
         manual[i]    = (i < MASK_W) ? cfg.manual_mask[i % MASK_W] : 1'b0;
         id_sel[i]    = in_id_ff == ID_W'(i);
         grant_sel[i] = grant.index == ID_W'(i);
         pending[i]   = nonzero[i] && in_use[i];
      end
   end

   rrem_rr_pick #(
      .MAX_EVENTS (MAX_EVENTS)
   ) u_pick (
      .pending (pending),
      .last    (last_ff),
      .grant   (grant)
   );

   // Command decode and checks.
   cmd_type      cmd;
   logic         id_ok;
   logic         set_ok, clear_ok, poll_ok, poll_consume;
   cnt_ctrl_type cnt_ctrl;

   assign cmd   = cmd_type'(in_cmd_ff);
   assign id_ok = in_id_ff < n_ev;

   always_comb begin
      set_ok       = 1'b0;
      clear_ok     = 1'b0;
      poll_ok      = 1'b0;
      poll_consume = 1'b0;
      lane_sel     = id_sel;
      case (cmd)
         CMD_SET: begin
            set_ok = id_ok && !(|(full & id_sel)) && (total_ff != TOTAL_MAX);
         end
         CMD_CLEAR: begin
            clear_ok = id_ok && (|(manual & id_sel & nonzero));
         end
         CMD_POLL: begin
            poll_ok      = (n_ev != '0) && (total_ff != '0) && grant.found;
            poll_consume = poll_ok && !(|(manual & grant_sel));
            lane_sel     = grant_sel;
         end
         default: begin
         end
      endcase
   end

   assign cnt_ctrl.clear_all = cfg_clear;
   assign cnt_ctrl.inc       = fire && set_ok;
   assign cnt_ctrl.dec       = fire && (clear_ok || poll_consume);

   rrem_counters #(
      .MAX_EVENTS  (MAX_EVENTS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_counters (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (cnt_ctrl),
      .lane_sel (lane_sel),
      .nonzero  (nonzero),
      .full     (full)
   );

   // Next values of the total, the last grant and both registers.
   always_comb begin
      total_in = total_ff;
      last_in  = last_ff;
      if (cfg_clear) begin
         total_in = '0;
         last_in  = '0;
      end else if (fire) begin
         if (set_ok) begin
            total_in = total_ff + TOTAL_W'(1);
         end else if ((clear_ok && (total_ff != '0)) || poll_consume) begin
            total_in = total_ff - TOTAL_W'(1);
         end
         if (poll_ok) begin
            last_in = grant.index[LAST_W-1:0];
         end
      end

      in_valid_in = in_valid_ff;
      in_cmd_in   = in_cmd_ff;
      in_id_in    = in_id_ff;
      if (req_ready) begin
         in_valid_in = req_ch.valid;
         in_cmd_in   = req_ch.command;
         in_id_in    = req_ch.event_id;
      end

      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_acc_in   = out_acc_ff;
      out_gv_in    = out_gv_ff;
      out_gi_in    = out_gi_ff;
      if (fire) begin
         out_valid_in = 1'b1;
         out_acc_in   = set_ok || clear_ok || poll_ok;
         out_gv_in    = poll_ok;
         out_gi_in    = poll_ok ? grant.index[GRANT_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         total_ff     <= '0;
         last_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         total_ff     <= total_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      in_cmd_ff  <= in_cmd_in;
      in_id_ff   <= in_id_in;
      out_acc_ff <= out_acc_in;
      out_gv_ff  <= out_gv_in;
      out_gi_ff  <= out_gi_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.accepted    = out_acc_ff;
   assign rsp_ch.grant_valid = out_gv_ff;
   assign rsp_ch.grant_index = out_gi_ff;

   // A zero total means no event in use has anything pending.
   a_total_tracks_lanes: assert property (@(posedge clock) disable iff (reset)
      (total_ff == '0) |-> !(|(nonzero & in_use)))
      else $error("total pending is zero while an event counter is nonzero");

   // While any event is in use, the last grant points at an event in use.
   a_last_in_range: assert property (@(posedge clock) disable iff (reset)
      (n_ev != '0) |-> ({{(ID_W-LAST_W){1'b0}}, last_ff} < n_ev))
      else $error("last granted index lies outside the events in use");

   // Writing event_count wipes every pending signal.
   a_clear_wipes: assert property (@(posedge clock) disable iff (reset)
      cfg_clear |=> (total_ff == '0) && (nonzero == '0) && (last_ff == '0))
      else $error("pending state survived an event_count write");

   // An item that cannot move on holds the input register closed.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input taken while the stalled item still waits");

endmodule

`default_nettype wire
